// ===== src/mfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_pkg: shared types, constants and font ROM
// Command codes, sequencer states and the 5x7 glyph table.
// ----------------------------------------------------------------------------
package mfb_pkg;

  localparam int unsigned ScreenWidthDef  = 128;
  localparam int unsigned ScreenHeightDef = 64;
  localparam int unsigned MaxDepth        = 8192;
  localparam logic [7:0] FirstCode   = 8'd32;
  localparam logic [7:0] LastCode    = 8'd126;
  localparam logic [2:0] GlyphCols   = 3'd5;
  localparam logic [7:0] CursorStep  = 8'd6;
  localparam logic [7:0] CursorLimit = 8'd122;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_PIXEL  = 3'd1,
    MODE_CHAR   = 3'd2,
    MODE_STRSET = 3'd3,
    MODE_STRCHR = 3'd4,
    MODE_READ   = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD,
    ST_WR,
    ST_RDOUT,
    ST_OUT
  } state_e;

  // One read-modify-write request from the sequencer to the store.
  typedef struct packed {
    logic       hit;   // target byte on screen
    logic [7:0] mask;  // bits to replace
    logic [7:0] bits;  // new values under mask
  } rmw_t;

  function automatic logic [39:0] glyph_f(input logic [6:0] r);
    logic [39:0] g;
    case (r)
      7'd0: g=40'h0000000000; 7'd1: g=40'h00004F0000; 7'd2: g=40'h0007000700;
      7'd3: g=40'h147F147F14; 7'd4: g=40'h242A7F2A12; 7'd5: g=40'h2313086462;
      7'd6: g=40'h3649552250; 7'd7: g=40'h0005030000; 7'd8: g=40'h001C224100;
      7'd9: g=40'h0041221C00; 7'd10: g=40'h14083E0814; 7'd11: g=40'h08083E0808;
      7'd12: g=40'h0050300000; 7'd13: g=40'h0808080808; 7'd14: g=40'h0060600000;
      7'd15: g=40'h2010080402; 7'd16: g=40'h3E514F453E; 7'd17: g=40'h00427F4000;
      7'd18: g=40'h4261514946; 7'd19: g=40'h2141454B31; 7'd20: g=40'h1814127F10;
      7'd21: g=40'h2745454539; 7'd22: g=40'h3C4A494930; 7'd23: g=40'h0171090503;
      7'd24: g=40'h3649494936; 7'd25: g=40'h064949291E; 7'd26: g=40'h0036360000;
      7'd27: g=40'h0056360000; 7'd28: g=40'h0814224100; 7'd29: g=40'h1414141414;
      7'd30: g=40'h0041221408; 7'd31: g=40'h0201510906; 7'd32: g=40'h324979413E;
      7'd33: g=40'h7E1111117E; 7'd34: g=40'h7F49494936; 7'd35: g=40'h3E41414122;
      7'd36: g=40'h7F4141221C; 7'd37: g=40'h7F49494941; 7'd38: g=40'h7F09090901;
      7'd39: g=40'h3E4149497A; 7'd40: g=40'h7F0808087F; 7'd41: g=40'h00417F4100;
      7'd42: g=40'h2040413F01; 7'd43: g=40'h7F08142241; 7'd44: g=40'h7F40404040;
      7'd45: g=40'h7F020C027F; 7'd46: g=40'h7F0408107F; 7'd47: g=40'h3E4141413E;
      7'd48: g=40'h7F09090906; 7'd49: g=40'h3E4151215E; 7'd50: g=40'h7F09192946;
      7'd51: g=40'h4649494931; 7'd52: g=40'h01017F0101; 7'd53: g=40'h3F4040403F;
      7'd54: g=40'h1F2040201F; 7'd55: g=40'h3F4038403F; 7'd56: g=40'h6314081463;
      7'd57: g=40'h0708700807; 7'd58: g=40'h6151494543; 7'd59: g=40'h007F414100;
      7'd60: g=40'h0204081020; 7'd61: g=40'h0041417F00; 7'd62: g=40'h0402010204;
      7'd63: g=40'h4040404040; 7'd64: g=40'h0001020400; 7'd65: g=40'h2054545478;
      7'd66: g=40'h7F48444438; 7'd67: g=40'h3844444420; 7'd68: g=40'h384444487F;
      7'd69: g=40'h3854545418; 7'd70: g=40'h087E090102; 7'd71: g=40'h0C5252523E;
      7'd72: g=40'h7F08040478; 7'd73: g=40'h00447D4000; 7'd74: g=40'h2040443D00;
      7'd75: g=40'h7F10284400; 7'd76: g=40'h00417F4000; 7'd77: g=40'h7C04180478;
      7'd78: g=40'h7C08040478; 7'd79: g=40'h3844444438; 7'd80: g=40'h7C14141408;
      7'd81: g=40'h081414147C; 7'd82: g=40'h7C08040408; 7'd83: g=40'h4854545420;
      7'd84: g=40'h043F444020; 7'd85: g=40'h3C4040207C; 7'd86: g=40'h1C2040201C;
      7'd87: g=40'h3C4030403C; 7'd88: g=40'h4428102844; 7'd89: g=40'h0C5050503C;
      7'd90: g=40'h4464544C44; 7'd91: g=40'h0008364100; 7'd92: g=40'h00007F0000;
      7'd93: g=40'h0041360800; 7'd94: g=40'h1008181008;
      default: g = 40'h0;
    endcase
    return g;
  endfunction

endpackage

// ===== src/mfb_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_store: framebuffer memory
// Single-port byte RAM with registered read; the sequencer does the masked read-modify-write.
// ----------------------------------------------------------------------------
module mfb_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);
  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/mfb_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_seq: command sequencer
// Walks clear sweeps, glyph columns and pages, one store access a cycle.
// ----------------------------------------------------------------------------
module mfb_seq #(
  parameter int unsigned ScreenWidth  = 128,
  parameter int unsigned ScreenHeight = 64,
  parameter int unsigned Depth        = 1024,
  parameter int unsigned AddrW        = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       mode_i,
  input  logic [7:0]       x_i,
  input  logic [7:0]       y_i,
  input  logic             color_i,
  input  logic [7:0]       char_code_i,
  input  logic [9:0]       byte_index_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       read_data_o,
  output logic             we_o,
  output logic [AddrW-1:0] addr_o,
  output logic [7:0]       wdata_o,
  input  logic [7:0]       rdata_i
);
  import mfb_pkg::*;

  state_e      state_q, state_d;
  logic [AddrW:0] cnt_q, cnt_d;        // clear sweep / general counter
  logic [2:0]  col_q, col_d;           // glyph column 0..4
  logic        pg_q, pg_d;             // lower or upper page of glyph
  logic [7:0]  gx_q, gx_d, gy_q, gy_d;
  logic [39:0] glyph_q, glyph_d;
  logic        pix_q, pix_d;           // single-pixel command
  logic        color_q, color_d;
  logic [7:0]  ccol_q, ccol_d, crow_q, crow_d;
  logic        stop_q, stop_d;
  logic        ovalid_q, ovalid_d;
  logic [7:0]  odata_q, odata_d;
  logic        oor_q, oor_d;
  logic [9:0]  bidx_q, bidx_d;
  rmw_t        rmw;

  // target coordinates of current access
  logic [7:0] px, py, line, pymax;
  logic [2:0] sh;
  logic [15:0] lin;
  logic [7:0] code;
  logic [6:0] grow;
  logic [7:0] rowok;                   // rows of the target page that are on screen

  always_comb begin
    px = gx_q + {5'd0, col_q};
    py = pix_q ? gy_q : (gy_q + {pg_q ? 5'd1 : 5'd0, 3'd0});
    sh = gy_q[2:0];
    line = glyph_q[39 - 8*col_q -: 8];
    // mask/bits in the byte at page py>>3; y row py aligned
    lin = pg_q ? ({line, 8'd0} >> (8 - sh)) : ({8'd0, line} << sh);
    for (int k = 0; k < 8; k++) begin
      rowok[k] = (32'({py[7:3], 3'(k)}) < ScreenHeight);
    end
    rmw.hit  = (32'(px) < ScreenWidth) && (rowok != 8'd0);
    if (pix_q) begin
      rmw.mask = (8'd1 << py[2:0]) & rowok;
      rmw.bits = color_q ? rmw.mask : 8'd0;
    end else if (pg_q) begin
      rmw.mask = (8'hFF >> (8 - sh)) & rowok;
      rmw.bits = lin[15:8];
    end else begin
      rmw.mask = (8'hFF << sh) & rowok;
      rmw.bits = lin[7:0];
    end
    pymax = py;
  end

  logic [AddrW-1:0] tgt;
  assign tgt = AddrW'(32'(px) + 32'(pymax[7:3]) * ScreenWidth);

  always_comb begin
    code = (char_code_i < FirstCode || char_code_i > LastCode) ? FirstCode : char_code_i;
    grow = 7'(code - FirstCode);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; cnt_q <= '0; stop_q <= 1'b1; ccol_q <= '0; crow_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; stop_q <= stop_d; ccol_q <= ccol_d;
      crow_q <= crow_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d; pg_q <= pg_d; gx_q <= gx_d; gy_q <= gy_d; glyph_q <= glyph_d;
    pix_q <= pix_d; color_q <= color_d; odata_q <= odata_d; oor_q <= oor_d;
    bidx_q <= bidx_d;
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; col_d = col_q; pg_d = pg_q; gx_d = gx_q;
    gy_d = gy_q; glyph_d = glyph_q; pix_d = pix_q; color_d = color_q;
    ccol_d = ccol_q; crow_d = crow_q; stop_d = stop_q; ovalid_d = ovalid_q;
    odata_d = odata_q; oor_d = oor_q; bidx_d = bidx_q;
    we_o = 1'b0; addr_o = tgt; wdata_o = (rdata_i & ~rmw.mask) | (rmw.bits & rmw.mask);
    in_stall_o = 1'b1;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = ovalid_q;
        if (in_valid_i && !ovalid_q) begin
          col_d = '0; pg_d = 1'b0; pix_d = 1'b0; color_d = color_i;
          gx_d = x_i; gy_d = y_i; glyph_d = glyph_f(grow);
          case (mode_i)
            MODE_CLEAR: begin cnt_d = '0; state_d = ST_CLEAR; end
            MODE_PIXEL: begin pix_d = 1'b1; state_d = ST_RD; end
            MODE_CHAR: state_d = ST_RD;
            MODE_STRSET: begin ccol_d = x_i; crow_d = y_i; stop_d = 1'b0; end
            MODE_STRCHR: begin
              if (!stop_q) begin
                if (char_code_i == 8'd0) stop_d = 1'b1;
                else begin
                  gx_d = ccol_q; gy_d = crow_q; state_d = ST_RD;
                  ccol_d = ccol_q + CursorStep;
                  if (ccol_q + CursorStep > CursorLimit) stop_d = 1'b1;
                end
              end
            end
            MODE_READ: begin
              bidx_d = byte_index_i; oor_d = 32'(byte_index_i) >= Depth;
              state_d = ST_RDOUT;
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        we_o = 1'b1; addr_o = cnt_q[AddrW-1:0]; wdata_o = 8'd0;
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == Depth - 1) state_d = ST_IDLE;
      end
      ST_RD: state_d = ST_WR;
      ST_WR: begin
        we_o = rmw.hit;
        state_d = ST_RD;
        if (pix_q) state_d = ST_IDLE;
        else if (!pg_q && sh != 3'd0) pg_d = 1'b1;
        else begin
          pg_d = 1'b0;
          if (col_q == GlyphCols - 3'd1) state_d = ST_IDLE;
          else col_d = col_q + 3'd1;
        end
      end
      ST_RDOUT: begin
        addr_o = AddrW'(bidx_q);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        odata_d = oor_q ? 8'd0 : rdata_i; ovalid_d = 1'b1; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign read_data_o = odata_q;
endmodule

// ===== src/mono_framebuffer_text_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_text_renderer: page framebuffer with 5x7 text
// Top level: sequencer plus single-port frame store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one command beat: clear,
//   pixel, char, string start, string char or read byte.
//   Output channel (out_valid_o / out_stall_i) returns one beat per read.
// Store use (one store port, read-modify-write per byte):
//   pixel, char and string char take two accesses per byte, one or two
//   pages per column; string start needs no store access, read does one
//   access plus delivery; clear writes one byte a cycle.
// Reset: a clearing pass over all Depth bytes zeroes the store; the input is
//   stalled until it ends. Cursor is zeroed and strings are stopped.
// Stall: the read result sits in an output register; while it is not taken
//   no new command is accepted.
// ----------------------------------------------------------------------------
module mono_framebuffer_text_renderer #(
  parameter int unsigned ScreenWidth  = mfb_pkg::ScreenWidthDef,
  parameter int unsigned ScreenHeight = mfb_pkg::ScreenHeightDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] x_i,
  input  logic [7:0] y_i,
  input  logic       color_i,
  input  logic [7:0] char_code_i,
  input  logic [9:0] byte_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);
  import mfb_pkg::*;

  // page count rounds up; store holds one byte per column per page
  localparam int unsigned Depth = ScreenWidth * ((ScreenHeight + 7) / 8);
  localparam int unsigned AddrW = $clog2(Depth);

  logic             we;
  logic [AddrW-1:0] addr;
  logic [7:0]       wdata, rdata;

  mfb_seq #(.ScreenWidth(ScreenWidth), .ScreenHeight(ScreenHeight),
            .Depth(Depth), .AddrW(AddrW)) u_seq (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .x_i, .y_i, .color_i,
    .char_code_i, .byte_index_i, .out_valid_o, .out_stall_i, .read_data_o,
    .we_o(we), .addr_o(addr), .wdata_o(wdata), .rdata_i(rdata)
  );

  mfb_store #(.Depth(Depth), .AddrW(AddrW)) u_store (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );
endmodule

// ===== src/mfb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_checker: port-level assertions
// Watches handshake behavior at the top level ports.
// ----------------------------------------------------------------------------
module mfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [2:0] mode_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o
);
  import mfb_pkg::*;

  // a waiting result holds its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o))
    else $error("result dropped or changed while stalled");

  // no command is taken while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted with result pending");

  // an accepted clear, pixel, char or read command makes the block busy next cycle
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i != MODE_STRSET && mode_i != MODE_STRCHR
      && mode_i <= MODE_READ |=> in_stall_o)
    else $error("block ready right after a multi-cycle command");

  // a read produces no result in the cycle right after acceptance
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i == MODE_READ |=> !out_valid_o)
    else $error("read result too early");
endmodule

bind mono_framebuffer_text_renderer mfb_checker u_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mono_framebuffer_text_renderer
// A directed command table runs first, then random scenes of pixels, glyphs
// and strings with reads. Every read beat is checked against a local image
// model of the framebuffer and cursor, or a typed-in value from the table.
// ----------------------------------------------------------------------------
module testbench;
  import mfb_pkg::*;

  localparam int unsigned Width    = 128;
  localparam int unsigned Height   = 64;
  localparam int unsigned Depth    = Width * ((Height + 7) / 8);
  localparam int unsigned DogLimit = 20000;
  localparam int unsigned NumRand  = 1430;
  localparam logic [8:0]  NoRef    = 9'h100;  // table row: use image model

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] mode_i = MODE_READ;
  logic [7:0] x_i = '0;
  logic [7:0] y_i = '0;
  logic       color_i = 1'b0;
  logic [7:0] char_code_i = '0;
  logic [9:0] byte_index_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] read_data_o;

  mono_framebuffer_text_renderer dut (.*);

  always #10 clk_i = ~clk_i;

  typedef struct {
    logic [2:0] mode;
    logic [7:0] x;
    logic [7:0] y;
    logic       color;
    logic [7:0] code;
    logic [9:0] index;
  } cmd_t;

  // Local image of the framebuffer and the text cursor.
  logic [7:0] image_q [Depth];
  logic [7:0] cur_col, cur_row;
  logic       str_done;

  logic [7:0] read_fifo [$];
  logic [8:0] fixed_fifo [$];  // typed-in value for the same beat, or NoRef
  int unsigned errors = 0;
  int unsigned dog = 0;
  bit          out_hold = 1'b0;  // receiver stall pattern on/off

  function automatic void plot(logic [7:0] px, logic [7:0] py, logic on);
    int unsigned idx;
    if (px >= Width || py >= Height) return;
    idx = px + (py >> 3) * Width;
    image_q[idx][py[2:0]] = on;
  endfunction

  function automatic void render_glyph(logic [7:0] gx, logic [7:0] gy, logic [7:0] code);
    logic [7:0]  c;
    logic [39:0] g;
    logic [7:0]  col;
    logic [7:0]  dx, dy;
    c = (code < 8'd32 || code > 8'd126) ? 8'd32 : code;
    g = glyph_f(7'(c - 8'd32));
    for (int i = 0; i < 5; i++) begin
      col = g[39 - 8*i -: 8];
      for (int j = 0; j < 8; j++) begin
        dx = gx + 8'(i);
        dy = gy + 8'(j);
        plot(dx, dy, col[j]);
      end
    end
  endfunction

  function automatic void apply_cmd(cmd_t c, logic [8:0] fixed);
    case (c.mode)
      MODE_CLEAR:  foreach (image_q[k]) image_q[k] = '0;
      MODE_PIXEL:  plot(c.x, c.y, c.color);
      MODE_CHAR:   render_glyph(c.x, c.y, c.code);
      MODE_STRSET: begin
        cur_col  = c.x;
        cur_row  = c.y;
        str_done = 1'b0;
      end
      MODE_STRCHR: begin
        if (!str_done) begin
          if (c.code == 8'd0) begin
            str_done = 1'b1;
          end else begin
            render_glyph(cur_col, cur_row, c.code);
            cur_col = cur_col + 8'd6;
            if (cur_col > 8'd122) str_done = 1'b1;
          end
        end
      end
      MODE_READ: begin
        read_fifo.push_back(c.index < Depth ? image_q[c.index] : 8'h00);
        fixed_fifo.push_back(fixed);
      end
      default: ;
    endcase
  endfunction

  // Output side: random stall, check each accepted read beat.
  always @(negedge clk_i) begin
    if (out_hold) out_stall_i <= ($urandom_range(0, 9) < 6);
    else if ($urandom_range(0, 99) == 0) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) dog <= 0;
    else dog <= dog + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (read_fifo.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected read beat: got %02h", read_data_o);
      end else begin
        logic [7:0] want;
        logic [8:0] fix;
        want = read_fifo.pop_front();
        fix  = fixed_fifo.pop_front();
        if (fix != NoRef && fix[7:0] != want) want = fix[7:0];
        if (read_data_o !== want) begin
          errors++;
          if (errors <= 10)
            $display("read_data mismatch: expected %02h got %02h", want, read_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (dog >= DogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Drive one command beat; valid may stay high into the next beat.
  task automatic send(cmd_t c, logic [8:0] fixed);
    int unsigned gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= c.mode;
    x_i          <= c.x;
    y_i          <= c.y;
    color_i      <= c.color;
    char_code_i  <= c.code;
    byte_index_i <= c.index;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_cmd(c, fixed);
    @(negedge clk_i);
  endtask

  function automatic cmd_t mk(logic [2:0] m, logic [7:0] x, logic [7:0] y, logic col,
                              logic [7:0] code, logic [9:0] idx);
    cmd_t c;
    c.mode = m; c.x = x; c.y = y; c.color = col; c.code = code; c.index = idx;
    return c;
  endfunction

  cmd_t       dir_cmd [$];
  logic [8:0] dir_fix [$];
  cmd_t       c;
  int unsigned r;

  initial begin
    foreach (image_q[k]) image_q[k] = '0;
    cur_col = '0; cur_row = '0; str_done = 1'b1;

    // Directed table: reads with a typed-in value where it is obvious.
    dir_cmd = '{
      mk(MODE_READ,   0,   0,   0, 0,   10'd0),      // store zero after reset
      mk(MODE_READ,   0,   0,   0, 0,   10'd1023),
      mk(MODE_STRCHR, 0,   0,   1, 65,  0),          // no string active: ignored
      mk(MODE_PIXEL,  0,   0,   1, 0,   0),
      mk(MODE_READ,   0,   0,   0, 0,   10'd0),
      mk(MODE_PIXEL,  127, 63,  1, 0,   0),
      mk(MODE_READ,   0,   0,   0, 0,   10'd1023),
      mk(MODE_PIXEL,  128, 0,   1, 0,   0),          // off screen
      mk(MODE_PIXEL,  0,   255, 1, 0,   0),
      mk(MODE_PIXEL,  0,   0,   0, 0,   0),
      mk(MODE_CHAR,   10,  3,   1, 48,  0),          // '0' glyph across two pages
      mk(MODE_READ,   0,   0,   0, 0,   10'd10),
      mk(MODE_READ,   0,   0,   0, 0,   10'd138),
      mk(MODE_CHAR,   254, 254, 0, 200, 0),          // wrap + unprintable
      mk(MODE_CHAR,   125, 60,  0, 127, 0),
      mk(MODE_READ,   0,   0,   0, 0,   10'd0),
      mk(MODE_STRSET, 110, 8,   0, 0,   0),
      mk(MODE_STRCHR, 0,   0,   0, 72,  0),
      mk(MODE_STRCHR, 0,   0,   0, 105, 0),          // cursor reaches limit
      mk(MODE_STRCHR, 0,   0,   0, 33,  0),
      mk(MODE_STRSET, 0,   40,  0, 0,   0),
      mk(MODE_STRCHR, 0,   0,   0, 0,   0),          // zero ends string
      mk(MODE_STRCHR, 0,   0,   0, 90,  0),
      mk(3'd6,        0,   0,   0, 0,   0),
      mk(MODE_CLEAR,  0,   0,   0, 0,   0),
      mk(MODE_READ,   0,   0,   0, 0,   10'd10)
    };
    dir_fix = '{9'h000, 9'h000, NoRef, NoRef, 9'h001, NoRef, 9'h080, NoRef, NoRef,
                NoRef, NoRef, NoRef, NoRef, NoRef, NoRef, NoRef, NoRef, NoRef,
                NoRef, NoRef, NoRef, NoRef, NoRef, NoRef, NoRef, 9'h000};

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_cmd[k]) send(dir_cmd[k], dir_fix[k]);

    for (int n = 0; n < NumRand; n++) begin
      // Hold off once until every read has come back.
      if (n == NumRand / 2) begin
        in_valid_i <= 1'b0;
        while (read_fifo.size() != 0) @(negedge clk_i);
      end
      out_hold = (n % 300) > 250;
      r = $urandom_range(0, 99);
      c = mk(MODE_READ, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
             10'($urandom));
      if (r < 3) c.mode = MODE_CLEAR;
      else if (r < 28) begin
        c.mode = MODE_PIXEL;
        if ($urandom_range(0, 3) != 0) begin
          c.x = 8'($urandom_range(0, Width - 1));
          c.y = 8'($urandom_range(0, Height - 1));
        end
      end else if (r < 40) begin
        c.mode = MODE_CHAR;
        if ($urandom_range(0, 3) != 0) begin
          c.x = 8'($urandom_range(0, Width + 4));
          c.y = 8'($urandom_range(0, Height + 4));
        end
      end else if (r < 45) begin
        c.mode = MODE_STRSET;
        if ($urandom_range(0, 3) != 0) begin
          c.x = 8'($urandom_range(0, 122));
          c.y = 8'($urandom_range(0, Height));
        end
      end else if (r < 62) begin
        c.mode = MODE_STRCHR;
        if ($urandom_range(0, 15) == 0) c.code = 8'd0;
        else if ($urandom_range(0, 3) != 0) c.code = 8'($urandom_range(32, 126));
      end else if (r < 64) c.mode = 3'($urandom_range(6, 7));
      else if ($urandom_range(0, 7) != 0) c.index = 10'($urandom_range(0, Depth - 1));
      send(c, NoRef);
    end
    in_valid_i <= 1'b0;
    out_hold = 1'b0;

    while (read_fifo.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== mono_framebuffer_text_renderer.f =====
src/mfb_pkg.sv
src/mfb_store.sv
src/mfb_seq.sv
src/mono_framebuffer_text_renderer.sv
src/mfb_checker.sv
verif/testbench.sv
